/* rtl/eegbp_pkg.sv */
// Shared types and constants for the EEG band power binner.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package eegbp_pkg;

   // Sizing
   localparam int CHANNELS   = 14;
   localparam int BANDS      = 5;
   localparam int ALPHA_BAND = 2;

   localparam int CH_W       = 4;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BAND_IDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int FREQ_W     = 12;
   localparam int POWER_W    = 24;
   localparam int SUM_W      = 32;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = SUM_W + GAIN_W;
   localparam int LEVEL_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_TOP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THETA_TOP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_TOP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_TOP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_TOP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_GAIN = 3'd5;

   // Reset values of the band upper bounds, delta first (1/16 Hz)
   localparam logic [FREQ_W-1:0] TOP_RESET [5] = '{12'd72, 12'd120, 12'd200, 12'd488, 12'd1600};
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6528;

   // Controller states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_ACCUM  = 6'b000100,
      ST_EREAD  = 6'b001000,
      ST_EMUL   = 6'b010000,
      ST_EOUT   = 6'b100000
   } eegbp_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic            load;
      logic            lookup;
      logic            accum;
      logic            emit_rd;
      logic            emit_mul;
      logic [CH_W-1:0] emit_ch;
   } eegbp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic item_last;
   } eegbp_status_type;

endpackage

/* rtl/eegbp_ctrl.sv */
// Sequencer of the EEG band power binner: item steps and the result burst.
// Depends on eegbp_pkg.
`timescale 1ns / 1ps

module eegbp_ctrl
   import eegbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  eegbp_status_type status,
   output eegbp_cmd_type    cmd,
   output logic             busy,
   output logic             rsp_strobe,
   output logic             rsp_final_channel,
   output logic [CH_W-1:0]  rsp_channel
);

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   eegbp_state_type state_ff, state_in;
   logic [CH_W-1:0] idx_ff, idx_in;

   // Next state and emission counter
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = status.item_last ? ST_EREAD : ST_IDLE;
         end
         ST_EREAD: begin
            state_in = ST_EMUL;
         end
         ST_EMUL: begin
            state_in = ST_EOUT;
         end
         ST_EOUT: begin
            if (idx_ff == LAST_CH) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end else begin
               state_in = ST_EREAD;
               idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd.load     = (state_ff == ST_IDLE) && start;
      cmd.lookup   = (state_ff == ST_LOOKUP);
      cmd.accum    = (state_ff == ST_ACCUM);
      cmd.emit_rd  = (state_ff == ST_EREAD);
      cmd.emit_mul = (state_ff == ST_EMUL);
      cmd.emit_ch  = idx_ff;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = (state_ff == ST_EOUT);
   assign rsp_final_channel = (state_ff == ST_EOUT) && (idx_ff == LAST_CH);
   assign rsp_channel       = idx_ff;

endmodule

/* rtl/eegbp_datapath.sv */
// Datapath of the EEG band power binner: registers, band lookup, accumulator
// memories with valid bits, saturating add and the colour level product.
// Depends on eegbp_pkg.
`timescale 1ns / 1ps

module eegbp_datapath
   import eegbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  eegbp_cmd_type         cmd,
   output eegbp_status_type      status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [FREQ_W-1:0]     req_bin_freq,
   input  logic [CH_W-1:0]       req_electrode,
   input  logic [POWER_W-1:0]    req_bin_power,
   input  logic                  req_spectrum_end,
   output logic [SUM_W-1:0]      rsp_delta_sum,
   output logic [SUM_W-1:0]      rsp_theta_sum,
   output logic [SUM_W-1:0]      rsp_alpha_sum,
   output logic [SUM_W-1:0]      rsp_beta_sum,
   output logic [SUM_W-1:0]      rsp_gamma_sum,
   output logic [LEVEL_W-1:0]    rsp_red_level,
   output logic [LEVEL_W-1:0]    rsp_green_level
);

   // Configuration registers
   logic [FREQ_W-1:0] top_ff [BANDS];
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANDS; b++) begin
            top_ff[b] <= TOP_RESET[b];
         end
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         for (int b = 0; b < BANDS; b++) begin
            if (csr_index == CSR_DELTA_TOP + CSR_IDX_W'(b)) begin
               top_ff[b] <= csr_wdata[FREQ_W-1:0];
            end
         end
         if (csr_index == CSR_LEVEL_GAIN) begin
            gain_ff <= csr_wdata[GAIN_W-1:0];
         end
      end
   end

   // Hold the accepted beat
   logic [FREQ_W-1:0]  freq_ff;
   logic [CH_W-1:0]    elec_ff;
   logic [POWER_W-1:0] power_ff;
   logic               last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         freq_ff  <= req_bin_freq;
         elec_ff  <= req_electrode;
         power_ff <= req_bin_power;
         last_ff  <= req_spectrum_end;
      end
   end

   assign status.item_last = last_ff;

   // Band lookup: first band in order whose bound is met
   logic [BAND_IDX_W-1:0] band_sel;
   logic                  band_hit;
   logic                  elec_ok;

   always_comb begin
      band_sel = '0;
      band_hit = 1'b0;
      for (int b = BANDS - 1; b >= 0; b--) begin
         if (freq_ff <= top_ff[b]) begin
            band_sel = BAND_IDX_W'(b);
            band_hit = 1'b1;
         end
      end
      elec_ok = ({1'b0, elec_ff} < (CH_W + 1)'(CHANNELS));
   end

   // Accumulator memories, one per band, and their valid bits
   logic [SUM_W-1:0]      mem [BANDS][CHANNELS];
   logic [CHANNELS-1:0]   valid_ff [BANDS];
   logic [SUM_W-1:0]      rd_ff [BANDS];
   logic [BANDS-1:0]      rdv_ff;
   logic [BAND_IDX_W-1:0] band_ff;
   logic                  hit_ff;
   logic [CH_IDX_W-1:0]   rd_addr;
   logic [CH_IDX_W-1:0]   wr_addr;

   assign rd_addr = cmd.emit_rd ? cmd.emit_ch[CH_IDX_W-1:0] : elec_ff[CH_IDX_W-1:0];
   assign wr_addr = elec_ff[CH_IDX_W-1:0];

   // Read all bands at one address; register the lookup result
   always_ff @(posedge clock) begin
      if (cmd.lookup || cmd.emit_rd) begin
         for (int b = 0; b < BANDS; b++) begin
            rd_ff[b]  <= mem[b][rd_addr];
            rdv_ff[b] <= valid_ff[b][rd_addr];
         end
      end
      if (cmd.lookup) begin
         band_ff <= band_sel;
         hit_ff  <= band_hit && elec_ok;
      end
   end

   // Saturating add of the bin power
   logic [SUM_W-1:0] acc_old;
   logic [SUM_W:0]   acc_wide;
   logic [SUM_W-1:0] acc_new;

   always_comb begin
      acc_old  = rdv_ff[band_ff] ? rd_ff[band_ff] : '0;
      acc_wide = {1'b0, acc_old} + (SUM_W + 1)'(power_ff);
      acc_new  = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accum && hit_ff) begin
         mem[band_ff][wr_addr] <= acc_new;
      end
   end

   // Set valid on write, drop a channel's row as it is read out
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANDS; b++) begin
            valid_ff[b] <= '0;
         end
      end else begin
         for (int b = 0; b < BANDS; b++) begin
            if (cmd.emit_rd) begin
               valid_ff[b][rd_addr] <= 1'b0;
            end else if (cmd.accum && hit_ff && (band_ff == BAND_IDX_W'(b))) begin
               valid_ff[b][wr_addr] <= 1'b1;
            end
         end
      end
   end

   // Capture band sums of the channel being emitted
   logic [SUM_W-1:0] sum_ff [BANDS];

   always_ff @(posedge clock) begin
      if (cmd.emit_mul) begin
         for (int b = 0; b < BANDS; b++) begin
            sum_ff[b] <= rdv_ff[b] ? rd_ff[b] : '0;
         end
      end
   end

   // Map band sums to the result fields; missing bands report zero
   logic [SUM_W-1:0] out_sum [5];

   for (genvar k = 0; k < 5; k++) begin : g_out_sum
      if (k < BANDS) begin : g_present
         assign out_sum[k] = sum_ff[k];
      end else begin : g_absent
         assign out_sum[k] = '0;
      end
   end

   assign rsp_delta_sum = out_sum[0];
   assign rsp_theta_sum = out_sum[1];
   assign rsp_alpha_sum = out_sum[2];
   assign rsp_beta_sum  = out_sum[3];
   assign rsp_gamma_sum = out_sum[4];

   // Colour level from the alpha sum
   logic [LEVEL_W-1:0] red;

   if (BANDS > ALPHA_BAND) begin : g_level
      logic [PROD_W-1:0] prod_ff;
      logic [SUM_W-1:0]  alpha_now;

      assign alpha_now = rdv_ff[ALPHA_BAND] ? rd_ff[ALPHA_BAND] : '0;

      always_ff @(posedge clock) begin
         if (cmd.emit_mul) begin
            prod_ff <= PROD_W'(alpha_now) * PROD_W'(gain_ff);
         end
      end

      // Clamp the product's integer part
      assign red = (prod_ff[PROD_W-1:GAIN_W] > SUM_W'(LEVEL_MAX))
                   ? LEVEL_MAX : prod_ff[GAIN_W+LEVEL_W-1:GAIN_W];
   end else begin : g_no_level
      assign red = '0;
   end

   assign rsp_red_level   = red;
   assign rsp_green_level = LEVEL_MAX - red;

endmodule

/* rtl/eeg_band_power_binner_top.sv */
// Top level of the EEG band power binner: sequencer plus datapath.
// Depends on eegbp_pkg, eegbp_ctrl and eegbp_datapath.
// Each accepted bin goes through lookup and memory read, then saturating add
// and write back, which ends its accumulator update.
// A bin marked as last is followed by 14 results, each made by row read,
// alpha gain multiply and present; a new bin is taken only while idle.
// Reset restores configuration defaults and clears all accumulator valid bits.
`timescale 1ns / 1ps

module eeg_band_power_binner_top
   import eegbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FREQ_W-1:0]     req_bin_freq,
   input  logic [CH_W-1:0]       req_electrode,
   input  logic [POWER_W-1:0]    req_bin_power,
   input  logic                  req_spectrum_end,
   output logic                  rsp_strobe,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [SUM_W-1:0]      rsp_delta_sum,
   output logic [SUM_W-1:0]      rsp_theta_sum,
   output logic [SUM_W-1:0]      rsp_alpha_sum,
   output logic [SUM_W-1:0]      rsp_beta_sum,
   output logic [SUM_W-1:0]      rsp_gamma_sum,
   output logic [LEVEL_W-1:0]    rsp_red_level,
   output logic [LEVEL_W-1:0]    rsp_green_level,
   output logic                  rsp_final_channel,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   eegbp_cmd_type    cmd;
   eegbp_status_type status;

   // Sequencer
   eegbp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .status            (status),
      .cmd               (cmd),
      .busy              (busy),
      .rsp_strobe        (rsp_strobe),
      .rsp_final_channel (rsp_final_channel),
      .rsp_channel       (rsp_channel)
   );

   // Datapath
   eegbp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_bin_freq     (req_bin_freq),
      .req_electrode    (req_electrode),
      .req_bin_power    (req_bin_power),
      .req_spectrum_end (req_spectrum_end),
      .rsp_delta_sum    (rsp_delta_sum),
      .rsp_theta_sum    (rsp_theta_sum),
      .rsp_alpha_sum    (rsp_alpha_sum),
      .rsp_beta_sum     (rsp_beta_sum),
      .rsp_gamma_sum    (rsp_gamma_sum),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level)
   );

endmodule

/* rtl/eegbp_checker.sv */
// Port-level checks for the EEG band power binner, bound to the top level.
// Depends on eegbp_pkg and eeg_band_power_binner_top.
`timescale 1ns / 1ps

module eegbp_checker
   import eegbp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [CH_W-1:0]    rsp_channel,
   input logic [LEVEL_W-1:0] rsp_red_level,
   input logic [LEVEL_W-1:0] rsp_green_level,
   input logic               rsp_final_channel
);

   // Results appear only inside a busy period
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat outside a busy period");

   // An accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // Green is the complement of red
   a_green: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_green_level == LEVEL_MAX - rsp_red_level))
      else $error("green level is not the complement of red");

   // Last result belongs to the last channel and ends the burst
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_final_channel |-> (rsp_strobe && (rsp_channel == CH_W'(CHANNELS - 1))))
      else $error("final flag on the wrong beat");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_channel) |=> !busy)
      else $error("block still busy after the final result");

endmodule

bind eeg_band_power_binner_top eegbp_checker u_eegbp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_channel       (rsp_channel),
   .rsp_red_level     (rsp_red_level),
   .rsp_green_level   (rsp_green_level),
   .rsp_final_channel (rsp_final_channel)
);
